// File: hdl/erm_pkg.sv
// shared types, constants and arithmetic helpers for the euler rotation matrix
`timescale 1ns / 1ps
package erm_pkg;

    // fixed formats of the ports
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 16;

    // number format and angle resolution
    localparam int FRACTION_BITS = 14;
    localparam int ANGLE_BITS    = 16;

    // derived widths
    localparam int TRIG_W       = FRACTION_BITS + 2;
    localparam int MAG_W        = FRACTION_BITS + 1;
    localparam int PROD_W       = 2 * TRIG_W;
    localparam int OCT_AW       = ANGLE_BITS - 2;
    localparam int QUARTER      = 1 << (ANGLE_BITS - 2);
    localparam int HALF_QUARTER = QUARTER / 2;
    localparam int OCT_DEPTH    = HALF_QUARTER + 1;

    // cycles from the accepting edge to the edge that takes the result
    localparam int LATENCY = 5;

    localparam real PI_R = 3.14159265358979323846;

    // radians per binary angle step
    localparam real ANGLE_STEP = 2.0 * PI_R / (2.0 ** ANGLE_BITS);

    // plus one and minus one in the sum format, and rounding offset
    localparam logic signed [TRIG_W:0] SAT_HI =
        {{(TRIG_W - FRACTION_BITS){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic signed [TRIG_W:0] SAT_LO = -SAT_HI;
    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        {{(PROD_W - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_x;
        logic signed [ANGLE_W-1:0] angle_y;
        logic signed [ANGLE_W-1:0] angle_z;
    } t_angles;

    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
    } t_matrix;

    // plus one in the output format
    localparam logic signed [OUT_W-1:0] OUT_ONE = OUT_W'(SAT_HI);

    // octant table entry: rounded sine in the upper half, cosine in the lower
    function automatic logic [2*MAG_W-1:0] trig_entry(input int k);
        real theta;
        real scale;
        logic [MAG_W-1:0] sv;
        logic [MAG_W-1:0] cv;
        theta = ANGLE_STEP * real'(k);
        scale = 2.0 ** FRACTION_BITS;
        sv    = MAG_W'($rtoi($floor($sin(theta) * scale + 0.5)));
        cv    = MAG_W'($rtoi($floor($cos(theta) * scale + 0.5)));
        return {sv, cv};
    endfunction

    // product rounded to nearest, ties upward
    function automatic logic signed [TRIG_W-1:0] rmul(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b) + ROUND_HALF;
        return TRIG_W'(p >>> FRACTION_BITS);
    endfunction

    // clamp a sum to plus or minus one
    function automatic logic signed [TRIG_W-1:0] sat(input logic signed [TRIG_W:0] v);
        logic signed [TRIG_W:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return TRIG_W'(c);
    endfunction

    // sign-aware sum of two terms
    function automatic logic signed [TRIG_W:0] add_s(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        return (TRIG_W+1)'(a) + (TRIG_W+1)'(b);
    endfunction

    function automatic logic signed [TRIG_W:0] sub_s(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        return (TRIG_W+1)'(a) - (TRIG_W+1)'(b);
    endfunction

    // fit a matrix term to the output field
    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [TRIG_W-1:0] v);
        return OUT_W'(v);
    endfunction

endpackage

// File: hdl/euler_rotation_matrix.sv
// xyz euler angles to 3x3 rotation matrix, five-stage pipeline
`timescale 1ns / 1ps
// o_done is registered from the valid pipeline and rises together with the
//   loaded result register
// throughput: one transaction per cycle, busy stays low; set by the single
//   read port of each angle's octant rom and one multiplier row per stage
// reset: synchronous active low, clears only the valid pipeline; the
//   lookup roms are constant and need no fill
module euler_rotation_matrix
    import erm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_angles i_angles,
    output logic    o_done,
    output t_matrix o_matrix
);

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travelling beside the data
    logic [LATENCY-2:0] r_valid;
    logic [LATENCY-2:0] n_valid;
    logic               r_done;

    assign n_valid = {r_valid[LATENCY-3:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_done  <= r_valid[LATENCY-2];
        end
    end

    // stages 1 and 2: sine and cosine of each angle
    logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

    erm_sincos u_sc_x (.i_clk(i_clk), .i_angle(i_angles.angle_x), .o_sin(sx), .o_cos(cx));
    erm_sincos u_sc_y (.i_clk(i_clk), .i_angle(i_angles.angle_y), .o_sin(sy), .o_cos(cy));
    erm_sincos u_sc_z (.i_clk(i_clk), .i_angle(i_angles.angle_z), .o_sin(sz), .o_cos(cz));

    // stage 3: two-factor products, negated sin y and a copy of sin y
    logic signed [TRIG_W-1:0] r3_cxsz, r3_sxcz, r3_sxsz, r3_cxcz;
    logic signed [TRIG_W-1:0] r3_m00, r3_m10, r3_m20, r3_m21, r3_m22, r3_sy;

    always_ff @(posedge i_clk) begin
        r3_cxsz <= rmul(cx, sz);
        r3_sxcz <= rmul(sx, cz);
        r3_sxsz <= rmul(sx, sz);
        r3_cxcz <= rmul(cx, cz);
        r3_m00  <= rmul(cy, cz);
        r3_m10  <= rmul(cy, sz);
        r3_m20  <= -sy;
        r3_m21  <= rmul(sx, cy);
        r3_m22  <= rmul(cx, cy);
        r3_sy   <= sy;
    end

    // stage 4: three-factor terms, second rounding by sin y
    logic signed [TRIG_W-1:0] r4_cxsz, r4_sxcz, r4_sxsz, r4_cxcz;
    logic signed [TRIG_W-1:0] r4_t01, r4_t02, r4_t11, r4_t12;
    logic signed [TRIG_W-1:0] r4_m00, r4_m10, r4_m20, r4_m21, r4_m22;

    always_ff @(posedge i_clk) begin
        r4_cxsz <= r3_cxsz;
        r4_sxcz <= r3_sxcz;
        r4_sxsz <= r3_sxsz;
        r4_cxcz <= r3_cxcz;
        r4_t01  <= rmul(r3_sxcz, r3_sy);
        r4_t02  <= rmul(r3_cxcz, r3_sy);
        r4_t11  <= rmul(r3_sxsz, r3_sy);
        r4_t12  <= rmul(r3_cxsz, r3_sy);
        r4_m00  <= r3_m00;
        r4_m10  <= r3_m10;
        r4_m20  <= r3_m20;
        r4_m21  <= r3_m21;
        r4_m22  <= r3_m22;
    end

    // stage 5: saturating sums, with the other terms passed through, into the result register
    t_matrix r_matrix;

    always_ff @(posedge i_clk) begin
        r_matrix.r00 <= to_out(r4_m00);
        r_matrix.r01 <= to_out(sat(sub_s(r4_t01, r4_cxsz)));
        r_matrix.r02 <= to_out(sat(add_s(r4_sxsz, r4_t02)));
        r_matrix.r10 <= to_out(r4_m10);
        r_matrix.r11 <= to_out(sat(add_s(r4_cxcz, r4_t11)));
        r_matrix.r12 <= to_out(sat(sub_s(r4_t12, r4_sxcz)));
        r_matrix.r20 <= to_out(r4_m20);
        r_matrix.r21 <= to_out(r4_m21);
        r_matrix.r22 <= to_out(r4_m22);
    end

    assign o_done   = r_done;
    assign o_matrix = r_matrix;

endmodule

// File: hdl/erm_sincos.sv
// two-stage sine and cosine of one binary angle from an octant lookup rom
`timescale 1ns / 1ps
module erm_sincos
    import erm_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic signed [TRIG_W-1:0]  o_sin,
    output logic signed [TRIG_W-1:0]  o_cos
);

    // octant rom, contents worked out at elaboration
    logic [2*MAG_W-1:0] rom [0:OCT_DEPTH-1];

    for (genvar g = 0; g < OCT_DEPTH; g++) begin : g_rom
        assign rom[g] = trig_entry(g);
    end

    // octant reduction of the angle
    logic [ANGLE_BITS-1:0] phase;
    logic [OCT_AW-1:0]     resid;
    logic [OCT_AW:0]       mirror;
    logic                  swap;
    logic [OCT_AW-1:0]     oct_addr;

    always_comb begin
        phase    = i_angle[ANGLE_BITS-1:0];
        resid    = phase[OCT_AW-1:0];
        mirror   = (OCT_AW+1)'(QUARTER) - (OCT_AW+1)'(resid);
        swap     = resid > OCT_AW'(HALF_QUARTER);
        oct_addr = swap ? mirror[OCT_AW-1:0] : resid;
    end

    // stage 1: registered rom read
    logic [2*MAG_W-1:0] r_rom_q;
    logic               r_swap;
    logic [1:0]         r_quad;

    always_ff @(posedge i_clk) begin
        r_rom_q <= rom[oct_addr];
        r_swap  <= swap;
        r_quad  <= phase[ANGLE_BITS-1:ANGLE_BITS-2];
    end

    // octant swap and quadrant signs
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] c0;
    logic signed [TRIG_W-1:0] n_sin;
    logic signed [TRIG_W-1:0] n_cos;

    always_comb begin
        if (r_swap) begin
            s0 = $signed(TRIG_W'(r_rom_q[MAG_W-1:0]));
            c0 = $signed(TRIG_W'(r_rom_q[2*MAG_W-1:MAG_W]));
        end else begin
            s0 = $signed(TRIG_W'(r_rom_q[2*MAG_W-1:MAG_W]));
            c0 = $signed(TRIG_W'(r_rom_q[MAG_W-1:0]));
        end
        case (r_quad)
            QUAD_0: begin
                n_sin = s0;
                n_cos = c0;
            end
            QUAD_1: begin
                n_sin = c0;
                n_cos = -s0;
            end
            QUAD_2: begin
                n_sin = -s0;
                n_cos = -c0;
            end
            default: begin
                n_sin = -c0;
                n_cos = s0;
            end
        endcase
    end

    // stage 2: signed sine and cosine
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [TRIG_W-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// File: hdl/erm_checker.sv
// port-level checks on the rotation matrix block, bound to the top level
`timescale 1ns / 1ps
module erm_checker
    import erm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_angles i_angles,
    input logic    o_done,
    input t_matrix o_matrix
);

    // every transaction gives its result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result strobe missing after accepted transaction");

    // no result without a transaction at the matching cycle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a transaction");

    // zero angles give ones on the diagonal and zeros in r01, r02 and r20
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_angles.angle_x == '0 && i_angles.angle_y == '0
                         && i_angles.angle_z == '0, LATENCY))
        |-> (o_matrix.r00 == OUT_ONE && o_matrix.r11 == OUT_ONE
             && o_matrix.r22 == OUT_ONE && o_matrix.r01 == '0
             && o_matrix.r02 == '0 && o_matrix.r20 == '0))
        else $error("zero angles did not give the identity");

    // no rotation about y leaves the bottom-left entry at zero
    a_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_angles.angle_y == '0, LATENCY)) |-> o_matrix.r20 == '0)
        else $error("bottom-left entry non-zero with zero y angle");

endmodule

bind euler_rotation_matrix erm_checker u_checker (.*);

// File: sim/tb_top.sv
// self-checking testbench for the euler rotation matrix pipeline
`timescale 1ns / 1ps
module tb_top;
    import erm_pkg::*;

    // cycles with no accepted transaction or result before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 480;

    typedef struct {
        t_angles angles;
        int      idle_pct;
        bit      drain;
    } t_angle_job;

    logic    i_clk;
    logic    i_rst_n  = 1'b0;
    logic    start    = 1'b0;
    t_angles i_angles = '0;
    logic    busy;
    logic    o_done;
    t_matrix o_matrix;

    t_angle_job angle_jobs[$];
    t_matrix    due_matrices[$];
    int         fault_count  = 0;
    int         stall_cycles = 0;

    euler_rotation_matrix i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_angles (i_angles),
        .o_done   (o_done),
        .o_matrix (o_matrix)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sine and cosine of a binary angle, rounded to the fraction grid
    function automatic void trig_of(input logic [ANGLE_W-1:0] ang, output int sn,
                                    output int cs);
        int         quarter;
        int         r;
        int         rr;
        int         mag_s;
        int         mag_c;
        int         s0;
        int         c0;
        real        theta;
        real        scale;
        logic [1:0] quad;
        quarter = 1 << (ANGLE_BITS - 2);
        quad    = ang[ANGLE_BITS-1 -: 2];
        r       = int'(ang[ANGLE_BITS-3:0]);
        rr      = (r > quarter / 2) ? quarter - r : r;
        scale   = 2.0 ** FRACTION_BITS;
        theta   = 2.0 * PI_R * real'(rr) / (2.0 ** ANGLE_BITS);
        mag_s   = $rtoi($floor($sin(theta) * scale + 0.5));
        mag_c   = $rtoi($floor($cos(theta) * scale + 0.5));
        // mirror about the octant boundary
        if (r > quarter / 2) begin
            s0 = mag_c;
            c0 = mag_s;
        end else begin
            s0 = mag_s;
            c0 = mag_c;
        end
        case (quad)
            QUAD_0: begin sn = s0;  cs = c0;  end
            QUAD_1: begin sn = c0;  cs = -s0; end
            QUAD_2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
    endfunction

    // fixed-point product, ties rounded upward
    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    endfunction

    // clamp a sum to plus or minus one
    function automatic longint clamp_unit(input longint v);
        longint one;
        one = longint'(1) << FRACTION_BITS;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    // full xyz rotation matrix for one set of angles
    function automatic t_matrix rotation_of(input t_angles a);
        int      sx, cx, sy, cy, sz, cz;
        longint  cxsz, sxcz, sxsz, cxcz;
        t_matrix m;
        trig_of(a.angle_x, sx, cx);
        trig_of(a.angle_y, sy, cy);
        trig_of(a.angle_z, sz, cz);
        cxsz  = round_mul(cx, sz);
        sxcz  = round_mul(sx, cz);
        sxsz  = round_mul(sx, sz);
        cxcz  = round_mul(cx, cz);
        m.r00 = OUT_W'(round_mul(cy, cz));
        m.r01 = OUT_W'(clamp_unit(round_mul(sxcz, sy) - cxsz));
        m.r02 = OUT_W'(clamp_unit(sxsz + round_mul(cxcz, sy)));
        m.r10 = OUT_W'(round_mul(cy, sz));
        m.r11 = OUT_W'(clamp_unit(cxcz + round_mul(sxsz, sy)));
        m.r12 = OUT_W'(clamp_unit(round_mul(cxsz, sy) - sxcz));
        m.r20 = OUT_W'(-longint'(sy));
        m.r21 = OUT_W'(round_mul(sx, cy));
        m.r22 = OUT_W'(round_mul(cx, cy));
        return m;
    endfunction

    function automatic void add_job(input int x, input int y, input int z, input int pct,
                                    input bit drain);
        t_angle_job j;
        j.angles.angle_x = ANGLE_W'(x);
        j.angles.angle_y = ANGLE_W'(y);
        j.angles.angle_z = ANGLE_W'(z);
        j.idle_pct       = pct;
        j.drain          = drain;
        angle_jobs.push_back(j);
    endfunction

    task automatic check_entry(input string name, input logic signed [OUT_W-1:0] want,
                               input logic signed [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fault_count++;
        end
    endtask

    // driver: presents queued angle sets, records the matrix due for each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                due_matrices.push_back(rotation_of(i_angles));
            end
            if (!(start && busy)) begin
                if (angle_jobs.size() != 0
                        && !(angle_jobs[0].drain && due_matrices.size() != 0)
                        && $urandom_range(99) >= angle_jobs[0].idle_pct) begin
                    i_angles <= angle_jobs[0].angles;
                    start    <= 1'b1;
                    void'(angle_jobs.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each strobed matrix with the oldest one due
    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n && o_done) begin
            if (due_matrices.size() == 0) begin
                $error("matrix strobed with no transaction outstanding");
                fault_count++;
            end else begin
                want = due_matrices.pop_front();
                check_entry("r00", want.r00, o_matrix.r00);
                check_entry("r01", want.r01, o_matrix.r01);
                check_entry("r02", want.r02, o_matrix.r02);
                check_entry("r10", want.r10, o_matrix.r10);
                check_entry("r11", want.r11, o_matrix.r11);
                check_entry("r12", want.r12, o_matrix.r12);
                check_entry("r20", want.r20, o_matrix.r20);
                check_entry("r21", want.r21, o_matrix.r21);
                check_entry("r22", want.r22, o_matrix.r22);
            end
        end
    end

    // watchdog on cycles without any transaction or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int tie_sin;
        int tie_cos;
        int sn;
        int cs;
        int pct;
        int kind;
        int x, y, z;

        // angles whose products land exactly halfway between two steps
        tie_sin = 0;
        tie_cos = 0;
        for (int a = 1; a < (1 << (ANGLE_BITS - 2)); a++) begin
            trig_of(ANGLE_W'(a), sn, cs);
            if (tie_sin == 0 && sn % 128 == 64) tie_sin = a;
            if (tie_cos == 0 && cs % 256 == 128) tie_cos = a;
        end

        // directed: extremes, quadrant and octant edges, gimbal lock, ties
        add_job(0, 0, 0, 38, 1'b0);
        add_job(-32768, -32768, -32768, 38, 1'b0);
        add_job(32767, 32767, 32767, 38, 1'b0);
        add_job(-1, 1, -1, 38, 1'b0);
        add_job(16384, -16384, 16384, 38, 1'b0);
        add_job(8192, 8193, 8191, 38, 1'b0);
        add_job(24576, -24576, 24577, 38, 1'b0);
        add_job(-8193, 24575, -8192, 38, 1'b0);
        add_job(0, 5000, -12000, 38, 1'b0);
        add_job(0, -30000, 21000, 38, 1'b0);
        add_job(1000, 16384, 1000, 38, 1'b0);
        add_job(-2000, 16384, -2000, 38, 1'b0);
        add_job(3000, -16384, -3000, 38, 1'b0);
        add_job(12345, -16384, 12345, 38, 1'b0);
        add_job(20000, 16384, 20001, 38, 1'b0);
        add_job(tie_sin, tie_cos, tie_cos, 38, 1'b0);
        add_job(-tie_sin, tie_cos, tie_cos, 38, 1'b0);
        add_job(tie_sin, 0, tie_cos, 38, 1'b0);
        add_job(-tie_sin, 16384, -tie_cos, 38, 1'b0);
        add_job(21845, -10923, 5461, 38, 1'b0);
        add_job(-21846, 10922, 32000, 38, 1'b0);
        add_job(16383, 16385, -16383, 38, 1'b0);

        // random: three idle phases, mostly full-range angles
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pct  = (i < RANDOM_ITEMS / 3) ? 38 : (i < 2 * RANDOM_ITEMS / 3) ? 64 : 0;
            kind = $urandom_range(99);
            x    = $urandom;
            y    = $urandom;
            z    = $urandom;
            if (kind < 15) begin
                // y-z only variant
                x = 0;
            end else if (kind < 30) begin
                // near gimbal lock, where the sums may saturate
                y = ($urandom_range(1) ? 16384 : -16384) + $urandom_range(4) - 2;
            end else if (kind < 40) begin
                // octant and quadrant edges
                x = ($urandom_range(7) << 13) + $urandom_range(2) - 1;
                y = ($urandom_range(7) << 13) + $urandom_range(2) - 1;
                z = ($urandom_range(7) << 13) + $urandom_range(2) - 1;
            end
            add_job(x, y, z, pct,
                    i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3
                    || $urandom_range(99) < 2);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (angle_jobs.size() != 0 || start || due_matrices.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/erm_pkg.sv
hdl/erm_sincos.sv
hdl/euler_rotation_matrix.sv
hdl/erm_checker.sv
sim/tb_top.sv
